// ===== design/bfhc_pkg.sv =====
// bfhc_pkg: shared types, constants and field helpers for the battery frame
// hysteresis control block. No dependencies; every other design file imports it.
`default_nettype none

package bfhc_pkg;

  // frame layout
  localparam logic [4:0] FRAME_LAST = 5'd17;   // position of the last byte of a frame
  localparam logic [4:0] KEEP_FROM  = 5'd8;    // first byte after the timestamp
  localparam logic [4:0] HB_LAST    = 5'd16;   // last byte of the heartbeat text
  localparam logic [4:0] BAT_END    = 5'd10;   // last byte of the battery field
  localparam logic [4:0] MAX_END    = 5'd13;   // last byte of the maximum field
  localparam logic [4:0] MIN_END    = 5'd16;   // last byte of the minimum field

  localparam logic [7:0] ASCII_ONE  = 8'h31;
  localparam logic [7:0] ASCII_PLUS = 8'h2B;
  localparam logic [7:0] ASCII_MIN  = 8'h2D;

  localparam logic [15:0] GAP_LIMIT_RST = 16'd750;
  localparam logic [31:0] HB_LIMIT_RST  = 32'd300000;

  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned LEVEL_W    = 11;

  typedef enum logic {
    CFG_BYTE_GAP = 1'b0,
    CFG_HB_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    EV_DATA      = 2'd0,
    EV_HEARTBEAT = 2'd1,
    EV_DROP      = 2'd2,
    EV_LOST      = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    PH_WS   = 2'd0,
    PH_DIG  = 2'd1,
    PH_DONE = 2'd2
  } parse_ph_t;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    event_t     event_res;
    level_t     battery_level;
    level_t     max_level;
    level_t     min_level;
    logic       plugged_in;
    logic       charge_enable;
    logic       plug_warning;
    logic [4:0] bytes_received;
  } result_t;

  // expected heartbeat text, index 0 is frame byte 8
  function automatic logic [7:0] hb_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48;  // H
      4'd1:    c = 8'h45;  // E
      4'd2:    c = 8'h41;  // A
      4'd3:    c = 8'h52;  // R
      4'd4:    c = 8'h54;  // T
      4'd5:    c = 8'h42;  // B
      4'd6:    c = 8'h45;  // E
      4'd7:    c = 8'h41;  // A
      4'd8:    c = 8'h54;  // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // atoi over three characters: whitespace, optional sign, digits
  function automatic level_t parse_field(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [7:0] c2);
    logic [2:0][7:0] cs;
    logic [7:0]      ch;
    parse_ph_t       ph;
    logic            neg;
    logic [9:0]      v;
    level_t          val;
    cs  = {c2, c1, c0};
    ph  = PH_WS;
    neg = 1'b0;
    v   = '0;
    for (int k = 0; k < 3; k++) begin
      ch = cs[k];
      case (ph)
        PH_WS: begin
          if (is_ws(ch)) begin
            ph = PH_WS;
          end else if (ch == ASCII_PLUS || ch == ASCII_MIN) begin
            neg = (ch == ASCII_MIN);
            ph  = PH_DIG;
          end else if (is_digit(ch)) begin
            v  = {6'd0, ch[3:0]};
            ph = PH_DIG;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_DIG: begin
          if (is_digit(ch)) begin
            v = v * 10'd10 + {6'd0, ch[3:0]};
          end else begin
            ph = PH_DONE;
          end
        end
        default: ph = PH_DONE;
      endcase
    end
    val = {1'b0, v};
    return neg ? LEVEL_W'(-val) : val;
  endfunction

endpackage

`default_nettype wire

// ===== design/bfhc_in_stage.sv =====
// bfhc_in_stage: input register for the byte/tick channel.
// Depends on bfhc_pkg for the item type.
`default_nettype none

module bfhc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bfhc_pkg::item_t in_item,
  input  wire logic           advance,    // held item is consumed this cycle
  output logic                item_valid,
  output bfhc_pkg::item_t     item
);
  import bfhc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_valid ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== design/bfhc_core.sv =====
// bfhc_core: frame assembly, incremental field parsing, gap and heartbeat
// timers, charge hysteresis and the configuration registers. Uses bfhc_pkg.
`default_nettype none

module bfhc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_index,
  input  wire logic [31:0]     cfg_wr_data,
  input  wire logic            step,        // process the held item now
  input  wire bfhc_pkg::item_t item,
  output logic                 res_valid,
  output bfhc_pkg::result_t    res
);
  import bfhc_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] gap_r, gap_nxt, gap_inc;
  logic [31:0] hb_cnt_r, hb_cnt_nxt, hb_inc;
  logic        charging_r, charging_nxt, chg_off;
  logic [15:0] gap_limit_r, gap_limit_nxt;
  logic [31:0] hb_limit_r, hb_limit_nxt;
  logic [7:0]  prev1_r, prev1_nxt, prev2_r, prev2_nxt;
  level_t      bat_r, bat_nxt, mx_r, mx_nxt, mn_r, mn_nxt;
  logic        hb_ok_r, hb_ok_nxt;
  logic        plugged;
  logic [3:0]  hb_idx;
  logic [4:0]  hb_off;

  assign gap_inc = (gap_r == 16'hFFFF) ? gap_r : gap_r + 16'd1;
  assign hb_inc  = (hb_cnt_r == 32'hFFFF_FFFF) ? hb_cnt_r : hb_cnt_r + 32'd1;
  assign hb_off  = pos_r - KEEP_FROM;
  assign hb_idx  = hb_off[3:0];
  assign plugged = (item.data_byte == ASCII_ONE);
  // switch turns off first, then may turn back on within the same frame
  assign chg_off = (bat_r >= mx_r) ? 1'b0 : charging_r;

  always_comb begin
    pos_nxt       = pos_r;
    gap_nxt       = gap_r;
    hb_cnt_nxt    = hb_cnt_r;
    charging_nxt  = charging_r;
    gap_limit_nxt = gap_limit_r;
    hb_limit_nxt  = hb_limit_r;
    prev1_nxt     = prev1_r;
    prev2_nxt     = prev2_r;
    bat_nxt       = bat_r;
    mx_nxt        = mx_r;
    mn_nxt        = mn_r;
    hb_ok_nxt     = hb_ok_r;
    res_valid     = 1'b0;
    res           = '0;
    res.charge_enable = charging_r;

    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BYTE_GAP: gap_limit_nxt = cfg_wr_data[15:0];
        CFG_HB_LIMIT: hb_limit_nxt  = cfg_wr_data;
        default:      gap_limit_nxt = gap_limit_r;
      endcase
    end

    if (step) begin
      if (item.kind == KIND_BYTE) begin
        gap_nxt   = '0;
        prev1_nxt = item.data_byte;
        prev2_nxt = prev1_r;
        if (pos_r == BAT_END) bat_nxt = parse_field(prev2_r, prev1_r, item.data_byte);
        if (pos_r == MAX_END) mx_nxt  = parse_field(prev2_r, prev1_r, item.data_byte);
        if (pos_r == MIN_END) mn_nxt  = parse_field(prev2_r, prev1_r, item.data_byte);
        // running match of the heartbeat text over bytes 8..16
        if (pos_r == KEEP_FROM) begin
          hb_ok_nxt = (item.data_byte == hb_char(hb_idx));
        end else if (pos_r > KEEP_FROM && pos_r <= HB_LAST) begin
          hb_ok_nxt = hb_ok_r && (item.data_byte == hb_char(hb_idx));
        end
        if (pos_r == FRAME_LAST) begin
          pos_nxt        = '0;
          hb_cnt_nxt     = '0;
          res_valid      = 1'b1;
          res.plugged_in = plugged;
          if (hb_ok_r) begin
            res.event_res    = EV_HEARTBEAT;
            res.plug_warning = !plugged && charging_r;
          end else begin
            charging_nxt      = (bat_r <= mn_r) ? 1'b1 : chg_off;
            res.event_res     = EV_DATA;
            res.battery_level = bat_r;
            res.max_level     = mx_r;
            res.min_level     = mn_r;
            res.charge_enable = charging_nxt;
            res.plug_warning  = !plugged && charging_nxt;
          end
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end else begin
        hb_cnt_nxt = hb_inc;
        if (pos_r != '0) begin
          if (gap_inc >= gap_limit_r) begin
            res_valid          = 1'b1;
            res.event_res      = EV_DROP;
            res.bytes_received = pos_r;
            pos_nxt            = '0;
            gap_nxt            = '0;
          end else begin
            gap_nxt = gap_inc;
          end
        end else if (hb_inc >= hb_limit_r) begin
          hb_cnt_nxt    = '0;
          res_valid     = 1'b1;
          res.event_res = EV_LOST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      gap_r       <= '0;
      hb_cnt_r    <= '0;
      charging_r  <= 1'b1;
      gap_limit_r <= GAP_LIMIT_RST;
      hb_limit_r  <= HB_LIMIT_RST;
      hb_ok_r     <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      gap_r       <= gap_nxt;
      hb_cnt_r    <= hb_cnt_nxt;
      charging_r  <= charging_nxt;
      gap_limit_r <= gap_limit_nxt;
      hb_limit_r  <= hb_limit_nxt;
      hb_ok_r     <= hb_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev1_r <= prev1_nxt;
    prev2_r <= prev2_nxt;
    bat_r   <= bat_nxt;
    mx_r    <= mx_nxt;
    mn_r    <= mn_nxt;
  end

endmodule

`default_nettype wire

// ===== design/bfhc_out_stage.sv =====
// bfhc_out_stage: result register and packing onto the result stream.
// Depends on bfhc_pkg for the result type and data width.
`default_nettype none

module bfhc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire bfhc_pkg::result_t res,
  output logic                   free,      // register can take a result this cycle
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [bfhc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser
);
  import bfhc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.event_res;
  assign out_tdata  = {7'd0, res_r.bytes_received, res_r.plug_warning, res_r.charge_enable,
                       res_r.plugged_in, res_r.min_level, res_r.max_level,
                       res_r.battery_level};

endmodule

`default_nettype wire

// ===== design/battery_frame_hysteresis_control.sv =====
// battery_frame_hysteresis_control: top level, input register, core logic and
// result register. Depends on bfhc_pkg, bfhc_in_stage, bfhc_core, bfhc_out_stage.
//
//   channel  dir  signals                          contents
//   in_      in   tvalid tready tdata[7:0] tuser   serial byte or 1 ms tick
//   out_     out  tvalid tready tdata[47:0] tuser  frame, drop or loss event
//   cfg_     in   wr_en index wr_data[31:0]        gap limit, heartbeat limit
//
// Each request passes the input register, the core logic and the result register in that
// order; one request is taken every cycle unless the result register is stalled.
// The input register waits only while the result register holds an untaken result.
// Requests that cause no result pass through without touching the result register.
// Reset (rst_n low, synchronous) clears both registers, the frame position and
// the timers, turns charging on and restores the limits to 750 and 300000.
`default_nettype none

module battery_frame_hysteresis_control (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tuser,    // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,   // [10:0] battery_level, [21:11] max_level,
                                        // [32:22] min_level, [33] plugged_in,
                                        // [34] charge_enable, [35] plug_warning,
                                        // [40:36] bytes_received, [47:41] zero
  output logic [1:0]       out_tuser,   // [1:0] event_res
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wr_data
);
  import bfhc_pkg::*;

  item_t   in_item, item;
  logic    item_valid, advance, out_free, res_valid;
  result_t res;

  assign in_item = '{kind: kind_t'(in_tuser), data_byte: in_tdata};
  assign advance = item_valid && out_free;

  bfhc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bfhc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .item        (item),
    .res_valid   (res_valid),
    .res         (res)
  );

  bfhc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== design/bfhc_checker.sv =====
// bfhc_checker: port-level checks for battery_frame_hysteresis_control,
// bound to the top level. Depends on the top level's ports and bfhc_pkg event codes.
`default_nettype none

module bfhc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  import bfhc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // input is never held off unless the result register is blocked
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free result register");

  // a dropped frame always reports a partial count
  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_DROP |-> out_tdata[40:36] != 5'd0 &&
    out_tdata[40:36] <= 5'd17)
    else $error("bad dropped byte count");

  // levels only travel with data frames
  a_levels_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_DATA |-> out_tdata[32:0] == 33'd0 &&
    out_tdata[47:41] == 7'd0)
    else $error("levels set on non-data event");

  // a fresh result comes from a request that passed the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching request");

endmodule

bind battery_frame_hysteresis_control bfhc_checker u_bfhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/battery_frame_hysteresis_control_tb.sv =====
// self-checking bench for battery_frame_hysteresis_control: streams serial bytes and
// ticks, predicts every frame, drop and loss event, checks each result field by field.
// depends on bfhc_pkg and the battery_frame_hysteresis_control rtl only.
`timescale 1ns / 100ps

module battery_frame_hysteresis_control_tb;
  import bfhc_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 6;
  localparam logic [71:0] HB_TEXT        = "HEARTBEAT";

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] data_byte
  logic        in_tuser = 1'b0;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [10:0] battery, [21:11] max, [32:22] min, [33] plugged,
                                  // [34] charge, [35] warning, [40:36] bytes, [47:41] zero
  logic [1:0]  out_tuser;         // [1:0] event_res
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;

  battery_frame_hysteresis_control dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // requests waiting for the driver, events waiting for the output
  item_t       rx_stream[$];
  result_t     expected_events[$];
  item_t       next_item;
  int unsigned queued_count = 0;

  // charger state as the block should hold it
  logic [15:0] gap_lim = GAP_LIMIT_RST;
  logic [31:0] hb_lim = HB_LIMIT_RST;
  logic [4:0]  frame_pos = '0;
  logic [7:0]  kept [10] = '{default: 8'd0};
  logic [15:0] gap_ticks = '0;
  logic [31:0] hb_ticks = '0;
  logic        charge_on = 1'b1;

  logic [7:0]  body [10];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  logic        in_taken = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h", $time, results_seen, what,
             got, want);
    mismatch_count++;
  endtask

  // three-character atoi over kept bytes
  function automatic level_t decode_level(input int first);
    int   i;
    int   v;
    bit   neg;
    logic [7:0] c;
    i = 0;
    v = 0;
    neg = 1'b0;
    while (i < 3 && (kept[first + i] == 8'd32 ||
                     (kept[first + i] >= 8'd9 && kept[first + i] <= 8'd13)))
      i++;
    if (i < 3 && (kept[first + i] == ASCII_PLUS || kept[first + i] == ASCII_MIN)) begin
      neg = (kept[first + i] == ASCII_MIN);
      i++;
    end
    while (i < 3) begin
      c = kept[first + i];
      if (c < "0" || c > "9") break;
      v = v * 10 + (int'(c) - 48);
      i++;
    end
    return level_t'(neg ? -v : v);
  endfunction

  task automatic step_charger(input item_t it, output bit fired, output result_t r);
    level_t bat;
    level_t mx;
    level_t mn;
    bit     plugged;
    bit     is_hb;
    int     k;
    fired = 1'b0;
    r = '0;
    if (it.kind == KIND_BYTE) begin
      if (frame_pos >= 5'd8 && frame_pos < 5'd18) kept[frame_pos - 5'd8] = it.data_byte;
      gap_ticks = '0;
      frame_pos = frame_pos + 5'd1;
      if (frame_pos == 5'd18) begin
        frame_pos = '0;
        hb_ticks = '0;
        plugged = (kept[9] == ASCII_ONE);
        is_hb = 1'b1;
        for (k = 0; k < 9; k++)
          if (kept[k] != HB_TEXT[71 - 8 * k -: 8]) is_hb = 1'b0;
        if (is_hb) begin
          r.event_res = EV_HEARTBEAT;
        end else begin
          bat = decode_level(0);
          mx = decode_level(3);
          mn = decode_level(6);
          // stop first, then restart, both can happen on one frame
          if (bat >= mx && charge_on) charge_on = 1'b0;
          if (bat <= mn && !charge_on) charge_on = 1'b1;
          r.event_res = EV_DATA;
          r.battery_level = bat;
          r.max_level = mx;
          r.min_level = mn;
        end
        r.plugged_in = plugged;
        r.charge_enable = charge_on;
        r.plug_warning = !plugged && charge_on;
        fired = 1'b1;
      end
    end else begin
      if (hb_ticks != '1) hb_ticks = hb_ticks + 32'd1;
      if (frame_pos != '0) begin
        if (gap_ticks != '1) gap_ticks = gap_ticks + 16'd1;
        if (gap_ticks >= gap_lim) begin
          r.event_res = EV_DROP;
          r.bytes_received = frame_pos;
          r.charge_enable = charge_on;
          frame_pos = '0;
          gap_ticks = '0;
          fired = 1'b1;
        end
      end else if (hb_ticks >= hb_lim) begin
        hb_ticks = '0;
        r.event_res = EV_LOST;
        r.charge_enable = charge_on;
        fired = 1'b1;
      end
    end
  endtask

  task automatic check_event(input result_t want);
    if (out_tuser != want.event_res) flag_mismatch("event", out_tuser, want.event_res);
    if (out_tdata[10:0] != want.battery_level)
      flag_mismatch("battery_level", out_tdata[10:0], want.battery_level);
    if (out_tdata[21:11] != want.max_level)
      flag_mismatch("max_level", out_tdata[21:11], want.max_level);
    if (out_tdata[32:22] != want.min_level)
      flag_mismatch("min_level", out_tdata[32:22], want.min_level);
    if (out_tdata[33] != want.plugged_in)
      flag_mismatch("plugged_in", out_tdata[33], want.plugged_in);
    if (out_tdata[34] != want.charge_enable)
      flag_mismatch("charge_enable", out_tdata[34], want.charge_enable);
    if (out_tdata[35] != want.plug_warning)
      flag_mismatch("plug_warning", out_tdata[35], want.plug_warning);
    if (out_tdata[40:36] != want.bytes_received)
      flag_mismatch("bytes_received", out_tdata[40:36], want.bytes_received);
    if (out_tdata[47:41] != '0) flag_mismatch("padding", out_tdata[47:41], 0);
  endtask

  // sampling, prediction and watchdog
  always @(posedge clk) begin
    item_t   it;
    result_t r;
    bit      fired;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_events.size() == 0) flag_mismatch("with nothing expected", out_tuser, 0);
        else check_event(expected_events.pop_front());
      end
      if (in_tvalid && in_tready) begin
        it.kind = kind_t'(in_tuser);
        it.data_byte = in_tdata;
        step_charger(it, fired, r);
        if (fired) expected_events.push_back(r);
      end
      in_taken <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("battery_frame_hysteresis_control_tb: errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (rx_stream.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = rx_stream.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_item.data_byte;
        in_tuser <= next_item.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure, with one long hold-off once armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it.kind = KIND_BYTE;
    it.data_byte = b;
    rx_stream.push_back(it);
    queued_count++;
  endtask

  task automatic push_ticks(input int unsigned n);
    item_t it;
    it.kind = KIND_TICK;
    it.data_byte = 8'($urandom_range(255));
    repeat (n) begin
      rx_stream.push_back(it);
      queued_count++;
    end
  endtask

  task automatic set_fields(input logic [23:0] bat, input logic [23:0] mx,
                            input logic [23:0] mn, input logic [7:0] plug);
    int k;
    for (k = 0; k < 3; k++) begin
      body[k] = bat[23 - 8 * k -: 8];
      body[3 + k] = mx[23 - 8 * k -: 8];
      body[6 + k] = mn[23 - 8 * k -: 8];
    end
    body[9] = plug;
  endtask

  task automatic set_heartbeat(input logic [7:0] plug);
    int k;
    for (k = 0; k < 9; k++) body[k] = HB_TEXT[71 - 8 * k -: 8];
    body[9] = plug;
  endtask

  // random timestamp, then the ten kept bytes; short tick gaps that stay under the limit
  task automatic push_frame(input bit with_ticks);
    int          k;
    int unsigned most;
    for (k = 0; k < 18; k++) begin
      if (k < 8) push_byte(8'($urandom_range(255)));
      else push_byte(body[k - 8]);
      if (with_ticks && k < 17 && gap_lim > 16'd1 && $urandom_range(9) == 0) begin
        most = (gap_lim > 16'd4) ? 3 : int'(gap_lim) - 1;
        push_ticks($urandom_range(1, most));
      end
    end
  endtask

  function automatic logic [23:0] rand_field();
    int unsigned v;
    logic [23:0] t;
    logic [7:0]  ws [6];
    ws = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    v = $urandom_range(999);
    t = {8'("0" + v / 100), 8'("0" + (v / 10) % 10), 8'("0" + v % 10)};
    case ($urandom_range(5))
      0, 1: begin
        if (v < 100 && $urandom_range(1)) t[23:16] = " ";
        if (v < 10 && $urandom_range(1)) t[15:8] = " ";
      end
      2: t[23:16] = $urandom_range(1) ? ASCII_MIN : ASCII_PLUS;
      3: t[23:16] = ws[$urandom_range(5)];
      4: t[15:8] = 8'($urandom_range(255));
      default: t = 24'($urandom);
    endcase
    return t;
  endfunction

  function automatic logic [7:0] rand_plug();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return ASCII_ONE;
    if (r < 80) return "0";
    return 8'($urandom_range(255));
  endfunction

  task automatic random_phase(input int unsigned n);
    int unsigned first;
    int unsigned r;
    first = queued_count;
    while (queued_count - first < n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        r = $urandom_range(99);
        if (r < 20) begin
          set_heartbeat(rand_plug());
        end else if (r < 25) begin
          set_heartbeat(rand_plug());
          body[$urandom_range(8)] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
        end else begin
          set_fields(rand_field(), rand_field(), rand_field(), rand_plug());
        end
        push_frame(1'b1);
        r = $urandom_range(99);
        if (r < 30) push_ticks($urandom_range(1, 3));
        else if (r < 40) push_ticks(hb_lim == 0 ? 1 : (hb_lim <= 64 ? int'(hb_lim) : 8));
      end else if (r < 85) begin
        // partial frame, left to time out when the gap limit is 64 or less
        repeat ($urandom_range(1, 17)) push_byte(8'($urandom_range(255)));
        push_ticks(gap_lim == 0 ? 1 : (gap_lim <= 64 ? int'(gap_lim) : 8));
      end else if ($urandom_range(1)) begin
        push_byte(8'($urandom_range(255)));
      end else begin
        push_ticks($urandom_range(1, 4));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BYTE_GAP) gap_lim = val[15:0];
    else hb_lim = val;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (rx_stream.size() != 0 || in_tvalid || expected_events.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 87;

    write_reg(CFG_BYTE_GAP, 32'd3);
    write_reg(CFG_HB_LIMIT, 32'd40);
    set_fields("999", "500", "100", ASCII_ONE);            // turns charging off
    push_frame(1'b0);
    set_fields("-99", "+99", " 50", "0");                  // back on, not plugged
    push_frame(1'b0);
    set_fields({8'd9, 8'd10, "5"}, {8'd11, 8'd12, "7"}, {8'd13, " ", "+"}, ASCII_ONE);
    push_frame(1'b0);
    set_fields("1-2", "abc", "-  ", "x");
    push_frame(1'b0);
    set_heartbeat(ASCII_ONE);
    push_frame(1'b0);
    set_heartbeat("0");
    body[5] = 8'd0;                                        // zero byte breaks the text
    push_frame(1'b0);
    set_fields("  0", "  0", "  0", "0");                  // off and on again in one frame
    push_frame(1'b0);
    repeat (17) push_byte(8'($urandom_range(255)));
    push_ticks(3);
    push_byte(8'hA5);
    push_ticks(3);
    push_ticks(40);
    settle();

    // zero limits fire on the first tick that checks them
    write_reg(CFG_BYTE_GAP, 32'd0);
    write_reg(CFG_HB_LIMIT, 32'd0);
    push_ticks(1);
    push_byte(8'h00);
    push_ticks(2);
    settle();

    write_reg(CFG_BYTE_GAP, 32'd2);
    write_reg(CFG_HB_LIMIT, 32'd25);
    random_phase(300);
    settle();

    send_idle_pct = 87;
    recv_idle_pct = 20;
    write_reg(CFG_BYTE_GAP, 32'd65535);
    write_reg(CFG_HB_LIMIT, 32'hFFFF_FFFF);
    random_phase(200);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_BYTE_GAP, 32'd1);
    write_reg(CFG_HB_LIMIT, 32'd1);
    random_phase(250);
    settle();

    // every idle tick raises a loss while the output is held off
    write_reg(CFG_BYTE_GAP, 32'd5);
    write_reg(CFG_HB_LIMIT, 32'd0);
    hold_armed = 1'b1;
    push_ticks(80);
    set_fields(rand_field(), rand_field(), rand_field(), rand_plug());
    push_frame(1'b1);
    push_ticks(80);
    settle();

    if (expected_events.size() != 0)
      flag_mismatch("never delivered", expected_events.size(), 0);
    if (mismatch_count == 0) begin
      $display("battery_frame_hysteresis_control_tb: clean");
    end else begin
      $display("battery_frame_hysteresis_control_tb: errors");
    end
    $finish;
  end

endmodule
